// ----- design/sot_pkg.sv -----
package sot_pkg;

    localparam int QW = 24;          // Q16.8 field width
    localparam int CW = 27;          // shrunk coordinates and edges
    localparam int DW = 28;          // deltas and radius sums
    localparam int PW = 2 * DW;      // squares, Q.16

    localparam logic [1:0] KIND_NULL   = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_RECT   = 2'd2;

    typedef logic signed [QW-1:0] q16_t;
    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] delta_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [PW:0]   sum_t;

    // near edge or center in x1/y1, far edge in x2/y2, radius in r
    typedef struct packed {
        logic   is_circle;
        logic   is_rect;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t r;
    } shape_t;

endpackage

// ----- design/sot_shape_shrink.sv -----
module sot_shape_shrink (
    input  logic [1:0]    kind_i,
    input  sot_pkg::q16_t x_i,
    input  sot_pkg::q16_t y_i,
    input  sot_pkg::q16_t w_i,
    input  sot_pkg::q16_t h_i,
    input  sot_pkg::q16_t margin_i,
    output sot_pkg::shape_t shape_o
);

    sot_pkg::coord_t x;
    sot_pkg::coord_t y;
    sot_pkg::coord_t w;
    sot_pkg::coord_t h;
    sot_pkg::coord_t m;

    assign x = sot_pkg::coord_t'(x_i);
    assign y = sot_pkg::coord_t'(y_i);
    assign w = sot_pkg::coord_t'(w_i);
    assign h = sot_pkg::coord_t'(h_i);
    assign m = sot_pkg::coord_t'(margin_i);

    always_comb begin
        shape_o.is_circle = 1'b0;
        shape_o.is_rect   = 1'b0;
        shape_o.x1        = x;
        shape_o.y1        = y;
        shape_o.x2        = x;
        shape_o.y2        = y;
        shape_o.r         = w;
        case (kind_i)
            sot_pkg::KIND_CIRCLE: begin
                shape_o.is_circle = 1'b1;
                shape_o.r         = w - m;
            end
            sot_pkg::KIND_RECT: begin
                // move in by the margin on every side
                shape_o.is_rect = 1'b1;
                shape_o.x1      = x + m;
                shape_o.y1      = y + m;
                shape_o.x2      = x + w - m;
                shape_o.y2      = y + h - m;
            end
            default: begin
                // null and unused codes never overlap
                shape_o.is_circle = 1'b0;
                shape_o.is_rect   = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/shape_overlap_test.sv -----
// Overlap test for a pair of shapes (null, circle or axis-aligned rectangle)
// after both are shrunk by a common margin. All values are signed Q16.8.
//
// Input channel s_*: one beat carries both shapes and the margin.
// Result channel m_*: one beat per input beat, m_overlap high on a hit.
//
// Stages: input register, shrink, clamp/delta, squares and compare, each
// ending in a register. Throughput: one beat per cycle while the receiver
// does not stall. The path through the squaring multipliers (28 x 28 bits)
// sets the stage split.
//
// The pipeline advances as a whole whenever the result register is empty
// or being taken; while the receiver stalls, m_overlap holds and s_ready
// stays low as long as a result beat waits. Kind 3 is treated as a null shape.
//
// Reset clears all valid flags and holds s_ready low; the first beat may be
// offered in the cycle after aresetn is released.
module shape_overlap_test (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_first_kind,
    input  sot_pkg::q16_t s_first_x,
    input  sot_pkg::q16_t s_first_y,
    input  sot_pkg::q16_t s_first_w,
    input  sot_pkg::q16_t s_first_h,
    input  logic [1:0]    s_second_kind,
    input  sot_pkg::q16_t s_second_x,
    input  sot_pkg::q16_t s_second_y,
    input  sot_pkg::q16_t s_second_w,
    input  sot_pkg::q16_t s_second_h,
    input  sot_pkg::q16_t s_margin,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_overlap
);

    logic advance;

    // input register
    logic          v0_reg;
    logic [1:0]    a_kind_reg;
    sot_pkg::q16_t a_x_reg;
    sot_pkg::q16_t a_y_reg;
    sot_pkg::q16_t a_w_reg;
    sot_pkg::q16_t a_h_reg;
    logic [1:0]    b_kind_reg;
    sot_pkg::q16_t b_x_reg;
    sot_pkg::q16_t b_y_reg;
    sot_pkg::q16_t b_w_reg;
    sot_pkg::q16_t b_h_reg;
    sot_pkg::q16_t margin_reg;

    // shrunk shapes
    logic            v1_reg;
    sot_pkg::shape_t sa_next;
    sot_pkg::shape_t sb_next;
    sot_pkg::shape_t sa_reg;
    sot_pkg::shape_t sb_reg;

    // deltas and radius
    logic            v2_reg;
    sot_pkg::shape_t c_sel;
    sot_pkg::shape_t o_sel;
    sot_pkg::delta_t lo_x;
    sot_pkg::delta_t hi_x;
    sot_pkg::delta_t lo_y;
    sot_pkg::delta_t hi_y;
    sot_pkg::delta_t d1_next;
    sot_pkg::delta_t d2_next;
    sot_pkg::delta_t rad_next;
    logic            round_next;
    logic            box_hit_next;
    sot_pkg::delta_t d1_reg;
    sot_pkg::delta_t d2_reg;
    sot_pkg::delta_t rad_reg;
    logic            round2_reg;
    logic            box_hit2_reg;

    // squares
    logic           v3_reg;
    sot_pkg::prod_t sq1_next;
    sot_pkg::prod_t sq2_next;
    sot_pkg::prod_t rr_next;
    sot_pkg::prod_t sq1_reg;
    sot_pkg::prod_t sq2_reg;
    sot_pkg::prod_t rr_reg;
    logic           rpos_reg;
    logic           round3_reg;
    logic           box_hit3_reg;

    // result register
    logic out_valid_reg;
    logic overlap_next;
    logic overlap_reg;

    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = aresetn && advance;
    assign m_valid   = out_valid_reg;
    assign m_overlap = overlap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v0_reg        <= s_valid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_kind_reg   <= s_first_kind;
            a_x_reg      <= s_first_x;
            a_y_reg      <= s_first_y;
            a_w_reg      <= s_first_w;
            a_h_reg      <= s_first_h;
            b_kind_reg   <= s_second_kind;
            b_x_reg      <= s_second_x;
            b_y_reg      <= s_second_y;
            b_w_reg      <= s_second_w;
            b_h_reg      <= s_second_h;
            margin_reg   <= s_margin;
            sa_reg       <= sa_next;
            sb_reg       <= sb_next;
            d1_reg       <= d1_next;
            d2_reg       <= d2_next;
            rad_reg      <= rad_next;
            round2_reg   <= round_next;
            box_hit2_reg <= box_hit_next;
            sq1_reg      <= sq1_next;
            sq2_reg      <= sq2_next;
            rr_reg       <= rr_next;
            rpos_reg     <= rad_reg > sot_pkg::delta_t'(0);
            round3_reg   <= round2_reg;
            box_hit3_reg <= box_hit2_reg;
            overlap_reg  <= overlap_next;
        end
    end

    sot_shape_shrink u_shrink_a (
        .kind_i   (a_kind_reg),
        .x_i      (a_x_reg),
        .y_i      (a_y_reg),
        .w_i      (a_w_reg),
        .h_i      (a_h_reg),
        .margin_i (margin_reg),
        .shape_o  (sa_next)
    );

    sot_shape_shrink u_shrink_b (
        .kind_i   (b_kind_reg),
        .x_i      (b_x_reg),
        .y_i      (b_y_reg),
        .w_i      (b_w_reg),
        .h_i      (b_h_reg),
        .margin_i (margin_reg),
        .shape_o  (sb_next)
    );

    // clamp: the sign of each edge delta tells on which side the center lies
    always_comb begin
        c_sel = sa_reg.is_circle ? sa_reg : sb_reg;
        o_sel = sa_reg.is_circle ? sb_reg : sa_reg;
        lo_x  = sot_pkg::delta_t'(c_sel.x1) - sot_pkg::delta_t'(o_sel.x1);
        hi_x  = sot_pkg::delta_t'(c_sel.x1) - sot_pkg::delta_t'(o_sel.x2);
        lo_y  = sot_pkg::delta_t'(c_sel.y1) - sot_pkg::delta_t'(o_sel.y1);
        hi_y  = sot_pkg::delta_t'(c_sel.y1) - sot_pkg::delta_t'(o_sel.y2);

        box_hit_next = sa_reg.is_rect && sb_reg.is_rect &&
                       (sa_reg.x1 < sb_reg.x2) && (sa_reg.x2 > sb_reg.x1) &&
                       (sa_reg.y1 < sb_reg.y2) && (sa_reg.y2 > sb_reg.y1);
        round_next   = (sa_reg.is_circle && (sb_reg.is_circle || sb_reg.is_rect)) ||
                       (sa_reg.is_rect && sb_reg.is_circle);

        if (sa_reg.is_circle && sb_reg.is_circle) begin
            d1_next  = sot_pkg::delta_t'(sb_reg.x1) - sot_pkg::delta_t'(sa_reg.x1);
            d2_next  = sot_pkg::delta_t'(sb_reg.y1) - sot_pkg::delta_t'(sa_reg.y1);
            rad_next = sot_pkg::delta_t'(sa_reg.r) + sot_pkg::delta_t'(sb_reg.r);
        end else begin
            if (lo_x < sot_pkg::delta_t'(0)) begin
                d1_next = lo_x;
            end else if (hi_x > sot_pkg::delta_t'(0)) begin
                d1_next = hi_x;
            end else begin
                d1_next = '0;
            end
            if (lo_y < sot_pkg::delta_t'(0)) begin
                d2_next = lo_y;
            end else if (hi_y > sot_pkg::delta_t'(0)) begin
                d2_next = hi_y;
            end else begin
                d2_next = '0;
            end
            rad_next = sot_pkg::delta_t'(c_sel.r);
        end
    end

    assign sq1_next = sot_pkg::prod_t'(d1_reg) * sot_pkg::prod_t'(d1_reg);
    assign sq2_next = sot_pkg::prod_t'(d2_reg) * sot_pkg::prod_t'(d2_reg);
    assign rr_next  = sot_pkg::prod_t'(rad_reg) * sot_pkg::prod_t'(rad_reg);

    always_comb begin
        if (round3_reg) begin
            overlap_next = rpos_reg &&
                           ((sot_pkg::sum_t'(sq1_reg) + sot_pkg::sum_t'(sq2_reg))
                            < sot_pkg::sum_t'(rr_reg));
        end else begin
            overlap_next = box_hit3_reg;
        end
    end

endmodule

// ----- design/sot_checker.sv -----
module sot_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_overlap
);

    // hold the result beat until it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_overlap))
        else $error("result payload changed while stalled");

    // no result beat out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty or draining output stage must not block the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked with free output stage");

endmodule

bind shape_overlap_test sot_checker u_sot_checker (.*);
